FILE: rtl/core/qnl_pkg.sv
// ----------------------------------------------------------------------------
// qnl_pkg: shared constants for the quaternion nlerp core
// Normalized magnitude, sum-of-squares and root widths.
// ----------------------------------------------------------------------------
package qnl_pkg;

  // the largest normalized magnitude lies in [2^29, 2^30), the others below 2^30
  localparam int VW = 30;
  // sum of four squares of normalized magnitudes
  localparam int SW = 2 * VW + 2;
  // integer square root of the sum
  localparam int RW = SW / 2;

endpackage

FILE: rtl/core/quaternion_nlerp_core.sv
// ----------------------------------------------------------------------------
// quaternion_nlerp_core: normalized linear interpolation of two quaternions
// Short-path blend of two Q1.15 quaternions, scaled to unit length.
// ----------------------------------------------------------------------------
// One request per clock while the output is not stalled, fully pipelined
// with no feedback between requests. The pipeline holds nine stages of
// multiply, dot product, blend and normalize, a 31-stage square root at
// one root bit per stage, a COMP_WIDTH-stage divider at one quotient
// bit per stage, and the output register. The whole pipeline advances when
// the output register is empty or taken, so s_axis_tready follows
// !m_axis_tvalid || m_axis_tready. A blend that sums to zero returns the
// identity quaternion with m_axis_tuser set.
module quaternion_nlerp_core #(
  parameter int COMP_WIDTH = 16,
  localparam int InW  = ((9 * COMP_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((4 * COMP_WIDTH + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend (lowest first)
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // r_w, r_x, r_y, r_z (lowest first)
  output logic [OutW-1:0] m_axis_tdata,
  // zero_length
  output logic            m_axis_tuser
);

  localparam int CW = COMP_WIDTH;
  localparam int VW = qnl_pkg::VW;
  localparam int SW = qnl_pkg::SW;
  localparam int RW = qnl_pkg::RW;
  localparam int MW = 2 * CW - 1;
  localparam int LW = $clog2(MW + 1);
  localparam logic [CW-1:0] One = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0] Max = {1'b0, {(CW - 1){1'b1}}};

  typedef struct packed {
    logic [3:0][VW-1:0] v;
    logic [3:0]         sgn;
    logic               zero;
  } side_t;

  typedef struct packed {
    logic [3:0] sgn;
    logic       zero;
  } flag_t;

  logic en;
  logic [8:0] vld_q;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: unpack and clamp blend
  logic signed [CW-1:0] a_q [4];
  logic signed [CW-1:0] b_q [4];
  logic [CW-1:0] t_raw, t_d, t_q, ti_q;

  assign t_raw = s_axis_tdata[8*CW +: CW];
  assign t_d   = (t_raw > One) ? One : t_raw;

  // stage 2: products
  logic signed [2*CW-1:0] dp_q [4];
  logic signed [2*CW:0]   pa_q [4];
  logic signed [2*CW:0]   pb_q [4];
  // stage 3: dot product
  logic signed [2*CW+1:0] dot_q;
  logic signed [2*CW:0]   pa3_q [4];
  logic signed [2*CW:0]   pb3_q [4];
  // stage 4: blend
  logic signed [2*CW:0]   m_q [4];
  // stage 5: magnitudes
  logic [MW-1:0] mag_q [4];
  logic [3:0]    sgn5_q;
  logic [MW-1:0] orv_q;
  // stage 6: leading one
  logic [MW-1:0] mag6_q [4];
  logic [3:0]    sgn6_q;
  logic [LW-1:0] len_d, len_q;
  logic          zero6_q;
  // stages 7..9
  side_t side7_q, side8_q, side9_q;
  logic [2*VW-1:0] sq_q [4];
  logic [SW-1:0]   s9_q;

  always_comb begin
    len_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv_q[i]) begin
        len_d = LW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= s_axis_tdata[i*CW +: CW];
        b_q[i] <= s_axis_tdata[(4+i)*CW +: CW];
      end
      t_q  <= t_d;
      ti_q <= One - t_d;

      for (int i = 0; i < 4; i++) begin
        dp_q[i] <= a_q[i] * b_q[i];
        pa_q[i] <= $signed({1'b0, ti_q}) * a_q[i];
        pb_q[i] <= $signed({1'b0, t_q}) * b_q[i];
      end

      dot_q <= (2*CW+2)'(dp_q[0]) + (2*CW+2)'(dp_q[1])
             + (2*CW+2)'(dp_q[2]) + (2*CW+2)'(dp_q[3]);
      pa3_q <= pa_q;
      pb3_q <= pb_q;

      // negate b when the dot product is negative
      for (int i = 0; i < 4; i++) begin
        m_q[i] <= dot_q[2*CW+1] ? (pa3_q[i] - pb3_q[i]) : (pa3_q[i] + pb3_q[i]);
      end

      begin
        logic [MW-1:0] acc;
        logic [2*CW:0] am;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
          am        = m_q[i][2*CW] ? -m_q[i] : m_q[i];
          mag_q[i] <= am[MW-1:0];
          sgn5_q[i] <= m_q[i][2*CW];
          acc       = acc | am[MW-1:0];
        end
        orv_q <= acc;
      end

      mag6_q  <= mag_q;
      sgn6_q  <= sgn5_q;
      len_q   <= len_d;
      zero6_q <= (orv_q == '0);

      // shift so the largest magnitude lands in [2^29, 2^30)
      for (int i = 0; i < 4; i++) begin
        side7_q.v[i] <= VW'({mag6_q[i], {VW{1'b0}}} >> len_q);
      end
      side7_q.sgn  <= sgn6_q;
      side7_q.zero <= zero6_q;

      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= side7_q.v[i] * side7_q.v[i];
      end
      side8_q <= side7_q;

      s9_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
      side9_q <= side8_q;
    end
  end

  // square root, side data travels alongside
  logic          sq_vld;
  logic [RW-1:0] root;
  side_t         side_dl_q [RW];

  qnl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[8]),
    .s_i     (s9_q),
    .valid_o (sq_vld),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dl_q[0] <= side9_q;
      for (int i = 1; i < RW; i++) begin
        side_dl_q[i] <= side_dl_q[i-1];
      end
    end
  end

  // divide, flags travel alongside
  logic               dv_vld;
  logic [3:0][CW-1:0] quo;
  flag_t              flag_dl_q [CW];

  qnl_div #(
    .COMP_WIDTH (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .v_i     (side_dl_q[RW-1].v),
    .d_i     (root),
    .valid_o (dv_vld),
    .q_o     (quo)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_dl_q[0].sgn  <= side_dl_q[RW-1].sgn;
      flag_dl_q[0].zero <= side_dl_q[RW-1].zero;
      for (int i = 1; i < CW; i++) begin
        flag_dl_q[i] <= flag_dl_q[i-1];
      end
    end
  end

  // output register: sign, saturate, identity on zero length
  logic [3:0][CW-1:0] res_d, res_q;
  logic               zero_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (flag_dl_q[CW-1].sgn[i]) begin
        res_d[i] = -quo[i];
      end else if (quo[i][CW-1]) begin
        res_d[i] = Max;
      end else begin
        res_d[i] = quo[i];
      end
    end
    if (flag_dl_q[CW-1].zero) begin
      res_d = '0;
      res_d[0] = Max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      zero_q <= flag_dl_q[CW-1].zero;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'(res_q);
  assign m_axis_tuser  = zero_q;

endmodule

FILE: rtl/core/qnl_isqrt.sv
// ----------------------------------------------------------------------------
// qnl_isqrt: pipelined integer square root
// One root bit per stage, floor(sqrt(s_i)) after RW stages.
// ----------------------------------------------------------------------------
module qnl_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [qnl_pkg::SW-1:0]   s_i,
  output logic                     valid_o,
  output logic [qnl_pkg::RW-1:0]   root_o
);

  localparam int RW = qnl_pkg::RW;
  localparam int W  = qnl_pkg::SW + 1;

  logic [W-1:0]  rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [RW-1:0] vld_q;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int K = RW - 1 - j;
    logic [W-1:0]  rem_in;
    logic [W-1:0]  trial;
    logic [RW-1:0] root_in;
    logic          vld_in;

    if (j == 0) begin : g_first
      assign rem_in  = {1'b0, s_i};
      assign root_in = '0;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    // (root + 2^K)^2 - root^2, root has no bits below K
    assign trial = (W'(root_in) << (K + 1)) | (W'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[j]  <= rem_in - trial;
          root_q[j] <= root_in | (RW'(1) << K);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

FILE: rtl/core/qnl_div.sv
// ----------------------------------------------------------------------------
// qnl_div: four-lane pipelined rounding divider
// Forms floor((v * 2^(CW-1) + floor(d/2)) / d), one quotient bit per stage.
// ----------------------------------------------------------------------------
module qnl_div #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [3:0][qnl_pkg::VW-1:0]         v_i,
  input  logic [qnl_pkg::RW-1:0]              d_i,
  output logic                                valid_o,
  output logic [3:0][COMP_WIDTH-1:0]          q_o
);

  localparam int CW = COMP_WIDTH;
  localparam int VW = qnl_pkg::VW;
  localparam int RW = qnl_pkg::RW;
  localparam int W  = VW + CW + 1;

  logic [3:0][W-1:0]  rem_q [CW];
  logic [3:0][CW-1:0] quo_q [CW];
  logic [RW-1:0]      d_q   [CW];
  logic [CW-1:0]      vld_q;

  for (genvar j = 0; j < CW; j++) begin : g_stage
    localparam int K = CW - 1 - j;
    logic [3:0][W-1:0]  rem_in;
    logic [3:0][CW-1:0] quo_in;
    logic [RW-1:0]      d_in;
    logic               vld_in;
    logic [W-1:0]       dsh;
    logic [3:0][W-1:0]  rem_nx;
    logic [3:0][CW-1:0] quo_nx;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_in[l] = (W'(v_i[l]) << (CW - 1)) + W'(d_i >> 1);
      end
      assign quo_in = '0;
      assign d_in   = d_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign d_in   = d_q[j-1];
      assign vld_in = vld_q[j-1];
    end

    assign dsh = W'(d_in) << K;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_nx[l] = rem_in[l] - dsh;
          quo_nx[l] = quo_in[l] | (CW'(1) << K);
        end else begin
          rem_nx[l] = rem_in[l];
          quo_nx[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_nx;
        quo_q[j] <= quo_nx;
        d_q[j]   <= d_in;
      end
    end
  end

  assign valid_o = vld_q[CW-1];
  assign q_o     = quo_q[CW-1];

endmodule

FILE: rtl/core/qnl_check.sv
// ----------------------------------------------------------------------------
// qnl_check: port-level checks for the quaternion nlerp core
// Watches the stream ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module qnl_check #(
  parameter int COMP_WIDTH = 16,
  localparam int OutW = ((4 * COMP_WIDTH + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic            m_axis_tuser
);

  localparam int CW = COMP_WIDTH;
  localparam logic [OutW-1:0] Ident = OutW'({1'b0, {(CW - 1){1'b1}}});

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // intake advances exactly when the output can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // zero length returns identity
  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == Ident)
    else $error("zero-length result is not identity");

  // nothing comes out of an idle pipe right after reset
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind quaternion_nlerp_core qnl_check #(
  .COMP_WIDTH (COMP_WIDTH)
) u_qnl_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
